// ===== hw/rtl/psc_pkg.sv =====
// Package for the pressure sensor compensation core.
// Holds the item codes, register indexes, shared structs and the 48-bit clamp.
// No dependencies.
`default_nettype none
package psc_pkg;

	localparam logic [1:0] KIND_CAL  = 2'd0;
	localparam logic [1:0] KIND_TEMP = 2'd1;
	localparam logic [1:0] KIND_PRES = 2'd2;

	localparam logic RES_TEMP = 1'b0;
	localparam logic RES_PRES = 1'b1;

	localparam logic CFG_TEMP_DIV = 1'b0;
	localparam logic CFG_PRES_DIV = 1'b1;

	localparam int CAL_BYTES = 18;
	localparam int DIV_W     = 50;
	localparam int DVS_W     = 31;

	localparam logic [22:0] TEMP_DIV_RESET = 23'd524288;
	localparam logic [22:0] PRES_DIV_RESET = 23'd1040384;

	// Reciprocal of 100 scaled by 2^32 and rounded up; exact for 26-bit dividends.
	localparam logic signed [31:0] FINAL_RECIP = 32'sd42949673;

	localparam logic signed [59:0] LIM48_HI = 60'sd140737488355327;
	localparam logic signed [59:0] LIM48_LO = -60'sd140737488355328;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

	typedef struct packed {
		logic        is_pres;
		logic [23:0] raw;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] temp;
		logic signed [15:0] pres;
		logic               sat;
	} res_t;

	typedef struct packed {
		logic               sat;
		logic signed [47:0] v;
	} clamp_t;

	function automatic clamp_t clamp48(input logic signed [59:0] x);
		clamp_t r;
		r.v   = x[47:0];
		r.sat = 1'b0;
		if (x > LIM48_HI) begin
			r.v   = LIM48_HI[47:0];
			r.sat = 1'b1;
		end else if (x < LIM48_LO) begin
			r.v   = LIM48_LO[47:0];
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/psc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on psc_pkg.
`default_nettype none
module psc_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [psc_pkg::DIV_W-1:0]    dividend,
	input  wire logic [psc_pkg::DVS_W-1:0]    divisor,
	output logic                              done,
	output logic [psc_pkg::DIV_W-1:0]         quotient
);
	import psc_pkg::*;

	logic [DVS_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIV_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/psc_front.sv =====
// Front end: accepts words, keeps the calibration bytes and queues samples.
// Depends on psc_pkg.
`default_nettype none
module psc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [1:0]    kind,
	input  wire logic [4:0]    byte_index,
	input  wire logic [23:0]   raw_value,
	output logic               full,
	input  wire logic          back_idle,
	input  wire logic          cmd_pop,
	output logic               cmd_valid,
	output psc_pkg::cmd_t      cmd,
	output psc_pkg::coef_t     coef
);
	import psc_pkg::*;

	logic [7:0] cal_q [CAL_BYTES];
	cmd_t       q_mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       push_cmd;
	logic       cal_block;

	assign cal_block = (kind == KIND_CAL) && (cnt_q != 2'd0 || !back_idle);
	assign full      = (cnt_q == 2'd2) || cal_block;
	assign accept    = push && !full;
	assign push_cmd  = accept && (kind == KIND_TEMP || kind == KIND_PRES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_BYTES; i++) begin
				cal_q[i] <= '0;
			end
		end else if (accept && kind == KIND_CAL) begin
			for (int i = 0; i < CAL_BYTES; i++) begin
				if (byte_index == 5'(i)) begin
					cal_q[i] <= raw_value[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push_cmd) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push_cmd) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cmd) begin
			q_mem[wr_q] <= '{is_pres: (kind == KIND_PRES), raw: raw_value};
		end
	end

	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_mem[rd_q];

	assign coef.c0  = {cal_q[0], cal_q[1][7:4]};
	assign coef.c1  = {cal_q[1][3:0], cal_q[2]};
	assign coef.c00 = {cal_q[3], cal_q[4], cal_q[5][7:4]};
	assign coef.c10 = {cal_q[5][3:0], cal_q[6], cal_q[7]};
	assign coef.c01 = {cal_q[8], cal_q[9]};
	assign coef.c11 = {cal_q[10], cal_q[11]};
	assign coef.c20 = {cal_q[12], cal_q[13]};
	assign coef.c21 = {cal_q[14], cal_q[15]};
	assign coef.c30 = {cal_q[16], cal_q[17]};
endmodule
`default_nettype wire

// ===== hw/rtl/psc_back.sv =====
// Back end: sequencer that scales samples and evaluates the compensation
// polynomials on one shared multiplier and the shared divider. Depends on psc_pkg, psc_div.
`default_nettype none
module psc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  psc_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  psc_pkg::coef_t     coef,
	input  wire logic [22:0]   temp_div,
	input  wire logic [22:0]   pres_div,
	input  wire logic          out_ready,
	output logic               out_valid,
	output psc_pkg::res_t      res,
	output logic               idle
);
	import psc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SDIV = 7'b0000010,
		ST_TMUL = 7'b0000100,
		ST_TFIN = 7'b0001000,
		ST_PMUL = 7'b0010000,
		ST_PACC = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic               is_pres_q;
	logic               neg_q;
	logic               sat_q;
	logic [3:0]         k_q;
	logic signed [31:0] st_q;
	logic signed [31:0] sp_q;
	logic signed [47:0] h_q;
	logic signed [47:0] g_q;
	logic signed [33:0] t_q;
	logic signed [57:0] prod_q;
	res_t               res_q;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DVS_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;

	logic signed [25:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [57:0] mul_p;

	logic signed [31:0] sc_val;
	logic               sc_sat;
	logic signed [15:0] fin_val;
	logic               fin_sat;
	logic [25:0]        fq;
	logic [23:0]        raw_mag;
	logic [22:0]        sel_div;
	logic signed [59:0] prod60;
	logic signed [59:0] sum_pt;
	clamp_t             r1;
	clamp_t             r2;
	logic signed [49:0] total;
	logic [DIV_W-1:0]   tot_mag;
	logic signed [57:0] tv;
	logic signed [41:0] tq;
	logic signed [15:0] t_res;
	logic               t_sat;

	psc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign mul_p  = mul_a * mul_b;
	assign prod60 = 60'(prod_q);
	assign sum_pt = prod60 + 60'(t_q);
	assign fq     = prod_q[57:32];

	always_comb begin
		mul_a = 26'(coef.c30);
		mul_b = sp_q;
		if (state_q == ST_TMUL) begin
			mul_a = 26'(coef.c1);
			mul_b = st_q;
		end else begin
			case (k_q)
				4'd0: mul_a = 26'(coef.c30);
				4'd1, 4'd3: mul_a = {2'b00, h_q[23:0]};
				4'd2, 4'd4: mul_a = 26'($signed(h_q[47:24]));
				4'd5: mul_a = 26'(coef.c21);
				4'd6, 4'd8: mul_a = {2'b00, g_q[23:0]};
				4'd7, 4'd9: mul_a = 26'($signed(g_q[47:24]));
				4'd11: mul_a = t_q[25:0];
				default: mul_a = 26'(coef.c01);
			endcase
			if (k_q == 4'd11) begin
				mul_b = FINAL_RECIP;
			end else if (k_q >= 4'd8) begin
				mul_b = st_q;
			end
		end
	end

	always_comb begin
		r1 = clamp48(prod60);
		r2 = r1;
		case (k_q)
			4'd0: r1 = clamp48((60'(coef.c20) <<< 24) + prod60);
			4'd2: begin
				r2 = clamp48(sum_pt);
				r1 = clamp48((60'(coef.c10) <<< 24) + 60'(r2.v));
			end
			4'd4: begin
				r2 = clamp48(sum_pt);
				r1 = clamp48((60'(coef.c00) <<< 24) + 60'(r2.v));
			end
			4'd5: r1 = clamp48((60'(coef.c11) <<< 24) + prod60);
			4'd7, 4'd9: r1 = clamp48(sum_pt);
			default: r1 = clamp48(prod60);
		endcase
		total   = 50'(h_q) + 50'(r1.v) + 50'(g_q);
		tot_mag = total[49] ? 50'(-total) : 50'(total);
	end

	always_comb begin
		raw_mag      = cmd.raw[23] ? 24'(-cmd.raw) : cmd.raw;
		sel_div      = cmd.is_pres ? pres_div : temp_div;
		div_start    = (state_q == ST_IDLE) && cmd_valid;
		div_dividend = {2'b00, raw_mag, 24'd0};
		div_divisor  = (sel_div == '0) ? 31'd1 : 31'(sel_div);
	end

	always_comb begin
		sc_sat  = 1'b0;
		fin_sat = 1'b0;
		if (neg_q) begin
			if (div_quo > 50'h80000000) begin
				sc_val = 32'sh80000000;
				sc_sat = 1'b1;
			end else begin
				sc_val = -$signed(div_quo[31:0]);
			end
			if (fq > 26'd32768) begin
				fin_val = -16'sd32768;
				fin_sat = 1'b1;
			end else begin
				fin_val = -$signed(fq[15:0]);
			end
		end else begin
			if (div_quo > 50'h7FFFFFFF) begin
				sc_val = 32'sh7FFFFFFF;
				sc_sat = 1'b1;
			end else begin
				sc_val = $signed(div_quo[31:0]);
			end
			if (fq > 26'd32767) begin
				fin_val = 16'sd32767;
				fin_sat = 1'b1;
			end else begin
				fin_val = $signed(fq[15:0]);
			end
		end
	end

	always_comb begin
		tv    = (58'(coef.c0) <<< 23) + prod_q;
		tq    = tv[57:16];
		t_sat = 1'b0;
		t_res = tq[15:0];
		if (tq > 42'sd32767) begin
			t_res = 16'sd32767;
			t_sat = 1'b1;
		end else if (tq < -42'sd32768) begin
			t_res = -16'sd32768;
			t_sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			st_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						k_q <= '0;
						if (is_pres_q) begin
							state_q <= ST_PMUL;
						end else begin
							st_q    <= sc_val;
							state_q <= ST_TMUL;
						end
					end
				end
				ST_TMUL: state_q <= ST_TFIN;
				ST_TFIN: state_q <= ST_OUT;
				ST_PMUL: state_q <= ST_PACC;
				ST_PACC: begin
					if (k_q == 4'd11) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= ST_PMUL;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				is_pres_q <= cmd.is_pres;
				neg_q     <= cmd.raw[23];
				sat_q     <= 1'b0;
			end
			ST_SDIV: begin
				if (div_done) begin
					sat_q <= sat_q | sc_sat;
					sp_q  <= sc_val;
					h_q   <= '0;
					g_q   <= '0;
				end
			end
			ST_TMUL, ST_PMUL: prod_q <= mul_p;
			ST_TFIN: begin
				res_q <= '{kind: RES_TEMP, temp: t_res, pres: 16'sd0, sat: sat_q | t_sat};
			end
			ST_PACC: begin
				case (k_q)
					4'd0: begin
						h_q   <= r1.v;
						sat_q <= sat_q | r1.sat;
					end
					4'd2, 4'd4: begin
						h_q   <= r1.v;
						sat_q <= sat_q | r1.sat | r2.sat;
					end
					4'd5, 4'd7, 4'd9: begin
						g_q   <= r1.v;
						sat_q <= sat_q | r1.sat;
					end
					4'd10: begin
						neg_q <= total[49];
						sat_q <= sat_q | r1.sat;
						t_q   <= 34'(tot_mag[49:24]);
					end
					4'd11: begin
						res_q <= '{kind: RES_PRES, temp: 16'sd0, pres: fin_val,
							sat: sat_q | fin_sat};
					end
					default: t_q <= 34'(prod_q >>> 24);
				endcase
			end
			default: ;
		endcase
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = state_q == ST_OUT;
	assign res       = res_q;
	assign idle      = state_q == ST_IDLE;
endmodule
`default_nettype wire

// ===== hw/rtl/pressure_sensor_compensation_core.sv =====
// Top level of the pressure sensor compensation core.
// Holds the divisor registers and the result register; depends on psc_pkg,
// psc_front and psc_back.
//
// Usage: input words enter through push/full. A calibration word with a byte
// index below 18 stores one byte; a temperature or pressure sample word yields
// one result word, read through empty/pop in arrival order. Configuration
// writes use cfg_valid / cfg_ready (always ready); they are to be made only
// while the core is idle, and the core itself does not enforce this.
// Each sample is first scaled by the one-bit-per-cycle divider and, for
// pressure, then taken through twelve steps on one multiplier, each a multiply
// state and an accumulate state, the last a reciprocal multiply for the
// division by 100.
// Samples are worked one at a time; two may wait in the queue between the
// front and back ends. A calibration word is held off (full high) until all
// earlier samples have been worked. When the receiver stalls, one result is
// held on the result ports and the sequencer waits with the next one.
// Reset clears the calibration bytes, the stored temperature and the queues,
// and sets the divisor registers to their default values.
`default_nettype none
module pressure_sensor_compensation_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         kind,
	input  wire logic [4:0]         byte_index,
	input  wire logic [23:0]        raw_value,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    result_kind,
	output logic signed [15:0]      temperature_q8,
	output logic signed [15:0]      pressure_hpa,
	output logic                    saturated,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [22:0]        cfg_data
);
	import psc_pkg::*;

	logic [22:0] temp_div_q;
	logic [22:0] pres_div_q;
	res_t        out_q;
	logic        valid_q;
	logic        back_idle;
	logic        cmd_pop;
	logic        cmd_valid;
	cmd_t        cmd;
	coef_t       coef;
	logic        out_ready;
	logic        back_valid;
	res_t        back_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_div_q <= TEMP_DIV_RESET;
			pres_div_q <= PRES_DIV_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEMP_DIV: temp_div_q <= cfg_data;
				CFG_PRES_DIV: pres_div_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.kind       (kind),
		.byte_index (byte_index),
		.raw_value  (raw_value),
		.full       (full),
		.back_idle  (back_idle),
		.cmd_pop    (cmd_pop),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.coef       (coef)
	);

	psc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.coef      (coef),
		.temp_div  (temp_div_q),
		.pres_div  (pres_div_q),
		.out_ready (out_ready),
		.out_valid (back_valid),
		.res       (back_res),
		.idle      (back_idle)
	);

	assign out_ready = !valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= back_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && back_valid) begin
			out_q <= back_res;
		end
	end

	assign empty          = !valid_q;
	assign result_kind    = out_q.kind;
	assign temperature_q8 = out_q.temp;
	assign pressure_hpa   = out_q.pres;
	assign saturated      = out_q.sat;
endmodule
`default_nettype wire

// ===== sim/pressure_sensor_compensation_core_tb.sv =====
// Self-checking testbench for the pressure sensor compensation core.
// Drives calibration and sample words, predicts each result and checks it in order.
// Depends on psc_pkg and pressure_sensor_compensation_core.
`timescale 1ns / 100ps
module pressure_sensor_compensation_core_tb;
	import psc_pkg::*;

	typedef logic signed [127:0] w_t;
	typedef enum {ST_WORD, ST_PAUSE, ST_CFG} step_e;
	typedef struct {
		step_e       op;
		logic [1:0]  kind;
		logic [4:0]  idx;
		logic [23:0] raw;
		logic        ci;
		logic [22:0] cd;
	} stim_t;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam w_t Q1    = w_t'(1) <<< 24;
	localparam w_t I32   = w_t'(2147483647);
	localparam w_t LIM48 = (w_t'(1) <<< 47) - 1;
	localparam w_t I16   = w_t'(32767);
	localparam int LIMIT = 1200000;
	localparam int SETTLE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] kind = '0;
	logic [4:0] byte_index = '0;
	logic [23:0] raw_value = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_index = 1'b0;
	logic [22:0] cfg_data = '0;
	logic full, empty, cfg_ready, result_kind, saturated;
	logic signed [15:0] temperature_q8, pressure_hpa;

	pressure_sensor_compensation_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.byte_index(byte_index), .raw_value(raw_value), .empty(empty), .pop(pop),
		.result_kind(result_kind), .temperature_q8(temperature_q8),
		.pressure_hpa(pressure_hpa), .saturated(saturated), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	logic [7:0] cal_bytes [CAL_BYTES];
	w_t stored_temp;
	logic [22:0] temp_div, pres_div;

	stim_t stim_q[$];
	res_t readings_q[$];
	int acc_cnt = 0, sent_cnt = 0, cfg_cnt = 0, cfg_sent = 0, res_cnt = 0, seen_cnt = 0;
	int errors = 0, cycles = 0, gap = 0, rx_gap = 0, settle = 0, n_items = 0;
	bit draining = 0, rx_hold = 0, calm = 0;

	function automatic w_t clip(input w_t x, input w_t lim, inout bit s);
		if (x > lim) begin
			s = 1;
			return lim;
		end
		if (x < -lim - 1) begin
			s = 1;
			return -lim - 1;
		end
		return x;
	endfunction

	function automatic w_t scaled(input logic [23:0] raw, input logic [22:0] dv, inout bit s);
		logic signed [23:0] rs;
		w_t x, d;
		rs = raw;
		x = rs;
		d = dv;
		if (d == 0)
			d = 1;
		return clip((x * Q1) / d, I32, s);
	endfunction

	function automatic void compensate(input logic [1:0] k, input logic [4:0] idx,
			input logic [23:0] raw, output bit has, output res_t r);
		logic signed [11:0] c0, c1;
		logic signed [19:0] c00, c10;
		logic signed [15:0] c01, c11, c20, c21, c30;
		w_t sp, h, g, v;
		bit s;
		has = 0;
		r = '0;
		s = 0;
		case (k)
			KIND_CAL: begin
				if (idx < CAL_BYTES)
					cal_bytes[idx] = raw[7:0];
			end
			KIND_TEMP: begin
				c0 = {cal_bytes[0], cal_bytes[1][7:4]};
				c1 = {cal_bytes[1][3:0], cal_bytes[2]};
				stored_temp = scaled(raw, temp_div, s);
				v = clip((c0 * (Q1 >>> 1) + c1 * stored_temp) >>> 16, I16, s);
				r.kind = RES_TEMP;
				r.temp = v[15:0];
				r.sat = s;
				has = 1;
			end
			KIND_PRES: begin
				c00 = {cal_bytes[3], cal_bytes[4], cal_bytes[5][7:4]};
				c10 = {cal_bytes[5][3:0], cal_bytes[6], cal_bytes[7]};
				c01 = {cal_bytes[8], cal_bytes[9]};
				c11 = {cal_bytes[10], cal_bytes[11]};
				c20 = {cal_bytes[12], cal_bytes[13]};
				c21 = {cal_bytes[14], cal_bytes[15]};
				c30 = {cal_bytes[16], cal_bytes[17]};
				sp = scaled(raw, pres_div, s);
				h = clip(c20 * Q1 + c30 * sp, LIM48, s);
				h = clip(c10 * Q1 + clip((h * sp) >>> 24, LIM48, s), LIM48, s);
				h = clip(c00 * Q1 + clip((h * sp) >>> 24, LIM48, s), LIM48, s);
				g = clip(c11 * Q1 + c21 * sp, LIM48, s);
				g = clip((g * sp) >>> 24, LIM48, s);
				g = clip((g * stored_temp) >>> 24, LIM48, s);
				v = h + clip(c01 * stored_temp, LIM48, s) + g;
				v = clip(v / (100 * Q1), I16, s);
				r.kind = RES_PRES;
				r.pres = v[15:0];
				r.sat = s;
				has = 1;
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] pick_raw();
		logic [23:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom_range(0, 1) ? 10'h3FF : 10'h000, 14'($urandom)};
			1: begin
				case ($urandom_range(0, 3))
					0: v = 24'h7FFFFF;
					1: v = 24'h800000;
					2: v = 24'h000000;
					default: v = 24'hFFFFFF;
				endcase
			end
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	task automatic add_word(input logic [1:0] k, input logic [4:0] idx, input logic [23:0] raw);
		stim_q.push_back('{ST_WORD, k, idx, raw, 1'b0, 23'd0});
		if (!(k == KIND_SPARE || (k == KIND_CAL && idx >= CAL_BYTES)))
			n_items++;
	endtask

	task automatic add_cfg(input logic [22:0] td, input logic [22:0] pd);
		stim_q.push_back('{ST_PAUSE, KIND_CAL, 5'd0, 24'd0, 1'b0, 23'd0});
		stim_q.push_back('{ST_CFG, KIND_CAL, 5'd0, 24'd0, CFG_TEMP_DIV, td});
		stim_q.push_back('{ST_CFG, KIND_CAL, 5'd0, 24'd0, CFG_PRES_DIV, pd});
	endtask

	task automatic add_random(input int count);
		int stop;
		bit tame;
		stop = n_items + count;
		while (n_items < stop) begin
			if ($urandom_range(0, 99) < 12) begin
				case ($urandom_range(0, 2))
					0: add_word(KIND_SPARE, 5'($urandom), 24'($urandom));
					1: add_word(KIND_CAL, 5'($urandom_range(18, 31)), 24'($urandom));
					default: add_word(2'($urandom_range(0, 2)), 5'($urandom),
						pick_raw());
				endcase
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					tame = $urandom_range(0, 1);
					for (int i = 0; i < CAL_BYTES; i++)
						add_word(KIND_CAL, 5'(i), (tame && i >= 8 && i % 2 == 0) ?
							{16'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00} :
							24'($urandom));
				end
				add_word(KIND_TEMP, 5'($urandom), pick_raw());
				repeat ($urandom_range(1, 8))
					add_word($urandom_range(0, 4) == 0 ? KIND_TEMP : KIND_PRES,
						5'($urandom), pick_raw());
			end
		end
	endtask

	always @(posedge clk) begin
		bit has;
		res_t r, want;
		if (arst_n) begin
			if (push && !full) begin
				compensate(kind, byte_index, raw_value, has, r);
				if (has)
					readings_q.push_back(r);
				acc_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TEMP_DIV)
					temp_div = cfg_data;
				else
					pres_div = cfg_data;
				cfg_cnt++;
			end
			if (pop && !empty) begin
				res_cnt++;
				if (readings_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: kind %0d temp %0d pres %0d sat %0d",
							result_kind, temperature_q8, pressure_hpa, saturated);
				end else begin
					want = readings_q.pop_front();
					if (result_kind !== want.kind || temperature_q8 !== want.temp ||
							pressure_hpa !== want.pres || saturated !== want.sat) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected kind %0d temp %0d pres %0d sat %0d, got kind %0d temp %0d pres %0d sat %0d",
								want.kind, want.temp, want.pres, want.sat, result_kind,
								temperature_q8, pressure_hpa, saturated);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		stim_t e;
		logic nxt_push, nxt_cfg;
		if (arst_n && !(push && acc_cnt != sent_cnt) && !(cfg_valid && cfg_cnt != cfg_sent)) begin
			nxt_push = 1'b0;
			nxt_cfg = 1'b0;
			if (gap > 0) begin
				gap--;
			end else if (draining) begin
				if (readings_q.size() == 0) begin
					if (settle == 0)
						draining = 0;
					else
						settle--;
				end
			end else if (stim_q.size() > 0) begin
				e = stim_q.pop_front();
				case (e.op)
					ST_WORD: begin
						kind <= e.kind;
						byte_index <= e.idx;
						raw_value <= e.raw;
						nxt_push = 1'b1;
						sent_cnt++;
						gap = pick_gap();
					end
					ST_CFG: begin
						cfg_index <= e.ci;
						cfg_data <= e.cd;
						nxt_cfg = 1'b1;
						cfg_sent++;
					end
					default: begin
						draining = 1;
						settle = SETTLE;
					end
				endcase
			end
			push <= nxt_push;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(negedge clk) begin
		if (res_cnt != seen_cnt) begin
			seen_cnt = res_cnt;
			rx_gap = pick_gap();
		end
		if (rx_gap > 0)
			rx_gap--;
		pop <= arst_n && rx_gap == 0 && !rx_hold;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles % 1500 == 0)
			calm = $urandom_range(0, 3) == 0;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		wait (acc_cnt >= 400);
		@(posedge clk);
		rx_hold = 1;
		repeat (700) @(posedge clk);
		rx_hold = 0;
	end

	initial begin
		for (int i = 0; i < CAL_BYTES; i++)
			cal_bytes[i] = 8'h00;
		stored_temp = 0;
		temp_div = TEMP_DIV_RESET;
		pres_div = PRES_DIV_RESET;

		add_cfg(TEMP_DIV_RESET, PRES_DIV_RESET);
		add_word(KIND_SPARE, 5'd31, 24'hFFFFFF);
		add_word(KIND_TEMP, 5'd0, 24'h7FFFFF);
		add_word(KIND_PRES, 5'd0, 24'h800000);
		for (int i = 0; i < CAL_BYTES; i++)
			add_word(KIND_CAL, 5'(i), {16'($urandom), (i % 2) ? 8'hFF : 8'h7F});
		add_word(KIND_CAL, 5'd18, 24'h0000AA);
		add_word(KIND_TEMP, 5'd0, 24'h7FFFFF);
		add_word(KIND_PRES, 5'd0, 24'h7FFFFF);
		add_word(KIND_TEMP, 5'd0, 24'h800000);
		add_word(KIND_PRES, 5'd0, 24'h800000);
		add_word(KIND_PRES, 5'd0, 24'h000000);
		add_random(210);
		add_cfg(23'd253952, 23'd253952);
		add_random(200);
		add_cfg(23'd7864320, 23'd7864320);
		add_random(200);
		add_cfg(23'd0, 23'h7FFFFF);
		add_random(100);
		repeat (2) begin
			add_cfg(23'($urandom_range(253952, 7864320)), 23'($urandom_range(253952, 7864320)));
			add_random(200);
		end
		add_cfg(TEMP_DIV_RESET, PRES_DIV_RESET);
		add_random(120);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		wait (stim_q.size() == 0 && !draining && !push && !cfg_valid && readings_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && readings_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
